@@ sv/gtc_pkg.sv @@
package gtc_pkg;

   localparam int CoordBits = 16;
   localparam int TFrac     = 16;
   localparam int DiffBits  = CoordBits + 1;
   localparam int ProdBits  = 2 * DiffBits;
   localparam int SumBits   = ProdBits + 1;
   localparam int LenBits   = 2 * CoordBits + 1;
   localparam int TBits     = TFrac + 1;
   localparam int PaddrBits = 5;

   localparam logic [PaddrBits-3:0] RegRedX   = 3'd0;
   localparam logic [PaddrBits-3:0] RegRedY   = 3'd1;
   localparam logic [PaddrBits-3:0] RegGreenX = 3'd2;
   localparam logic [PaddrBits-3:0] RegGreenY = 3'd3;
   localparam logic [PaddrBits-3:0] RegBlueX  = 3'd4;
   localparam logic [PaddrBits-3:0] RegBlueY  = 3'd5;
   localparam logic [PaddrBits-3:0] RegValid  = 3'd6;

   localparam int QueueDepth = 2;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic signed [DiffBits-1:0] diff_type;
   typedef logic signed [SumBits-1:0] sum_type;
   typedef logic [LenBits-1:0] len_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      logic      unchanged;
   } item_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      diff_type  ex;
      diff_type  ey;
      logic      degen;
      logic      t_zero;
      logic      t_one;
      len_type   dot;
      len_type   len2;
   } edge_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      diff_type  ex;
      diff_type  ey;
      logic      degen;
      logic [TBits-1:0] t;
   } proj_type;

endpackage

@@ sv/gtc_front.sv @@
module gtc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gtc_pkg::coord_type   px,
   input  gtc_pkg::coord_type   py,
   input  gtc_pkg::coord_type   rx,
   input  gtc_pkg::coord_type   ry,
   input  gtc_pkg::coord_type   gx,
   input  gtc_pkg::coord_type   gy,
   input  gtc_pkg::coord_type   bx,
   input  gtc_pkg::coord_type   by,
   input  logic                 gamut_on,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gtc_pkg::item_type    out_item,
   output gtc_pkg::edge_type    out_edge [3]
);

   // Stage 1: differences and products. Stage 2: cross signs, dot, len2.
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic adv1, adv2;
   gtc_pkg::coord_type s1_px_ff, s1_py_ff, s2_px_ff, s2_py_ff;
   logic s1_on_ff;
   gtc_pkg::coord_type s1_ax_ff [3], s1_ay_ff [3];
   gtc_pkg::diff_type  s1_ex_ff [3], s1_ey_ff [3];
   logic signed [gtc_pkg::ProdBits-1:0] s1_c1_ff [3], s1_c2_ff [3];
   logic signed [gtc_pkg::ProdBits-1:0] s1_d1_ff [3], s1_d2_ff [3];
   logic [gtc_pkg::ProdBits-1:0] s1_l1_ff [3], s1_l2_ff [3];
   gtc_pkg::item_type s2_item_ff;
   gtc_pkg::edge_type s2_edge_ff [3];
   gtc_pkg::coord_type va_x [3], va_y [3], vb_x [3], vb_y [3];

   assign va_x = '{rx, gx, bx};
   assign va_y = '{ry, gy, by};
   assign vb_x = '{gx, bx, rx};
   assign vb_y = '{gy, by, ry};

   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_ready = adv1;
   assign s1_valid_in = adv1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_px_ff <= px;
         s1_py_ff <= py;
         s1_on_ff <= gamut_on;
         for (int i = 0; i < 3; i++) begin
            logic signed [gtc_pkg::DiffBits-1:0] ex, ey, qx, qy;
            ex = $signed({1'b0, vb_x[i]}) - $signed({1'b0, va_x[i]});
            ey = $signed({1'b0, vb_y[i]}) - $signed({1'b0, va_y[i]});
            qx = $signed({1'b0, px}) - $signed({1'b0, va_x[i]});
            qy = $signed({1'b0, py}) - $signed({1'b0, va_y[i]});
            s1_ax_ff[i] <= va_x[i];
            s1_ay_ff[i] <= va_y[i];
            s1_ex_ff[i] <= ex;
            s1_ey_ff[i] <= ey;
            s1_c1_ff[i] <= ex * qy;
            s1_c2_ff[i] <= ey * qx;
            s1_d1_ff[i] <= qx * ex;
            s1_d2_ff[i] <= qy * ey;
            s1_l1_ff[i] <= gtc_pkg::ProdBits'(ex * ex);
            s1_l2_ff[i] <= gtc_pkg::ProdBits'(ey * ey);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         logic neg, pos;
         neg = 1'b0;
         pos = 1'b0;
         for (int i = 0; i < 3; i++) begin
            gtc_pkg::sum_type cr, dt;
            logic [gtc_pkg::SumBits-1:0] ln;
            cr = gtc_pkg::SumBits'(s1_c1_ff[i]) - gtc_pkg::SumBits'(s1_c2_ff[i]);
            dt = gtc_pkg::SumBits'(s1_d1_ff[i]) + gtc_pkg::SumBits'(s1_d2_ff[i]);
            ln = {1'b0, s1_l1_ff[i]} + {1'b0, s1_l2_ff[i]};
            neg = neg | cr[gtc_pkg::SumBits-1];
            pos = pos | (!cr[gtc_pkg::SumBits-1] && cr != '0);
            s2_edge_ff[i].ax <= s1_ax_ff[i];
            s2_edge_ff[i].ay <= s1_ay_ff[i];
            s2_edge_ff[i].ex <= s1_ex_ff[i];
            s2_edge_ff[i].ey <= s1_ey_ff[i];
            s2_edge_ff[i].degen <= (ln == '0);
            s2_edge_ff[i].t_zero <= dt[gtc_pkg::SumBits-1] || dt == '0;
            s2_edge_ff[i].t_one <= !dt[gtc_pkg::SumBits-1] &&
                                   ($unsigned(dt) >= ln);
            s2_edge_ff[i].dot <= gtc_pkg::LenBits'(dt);
            s2_edge_ff[i].len2 <= gtc_pkg::LenBits'(ln);
         end
         s2_item_ff.px <= s1_px_ff;
         s2_item_ff.py <= s1_py_ff;
         s2_item_ff.unchanged <= !s1_on_ff || !(neg && pos);
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item = s2_item_ff;
   assign out_edge = s2_edge_ff;

endmodule

@@ sv/gtc_queue.sv @@
module gtc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gtc_pkg::item_type  in_item,
   input  gtc_pkg::edge_type  in_edge [3],
   output logic               out_valid,
   input  logic               out_ready,
   output gtc_pkg::item_type  out_item,
   output gtc_pkg::edge_type  out_edge [3]
);

   logic [1:0] count_ff, count_in;
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic push, pop;
   gtc_pkg::item_type item_ff [gtc_pkg::QueueDepth];
   gtc_pkg::edge_type edge_ff [gtc_pkg::QueueDepth][3];

   assign in_ready = count_ff != 2'(gtc_pkg::QueueDepth);
   assign out_valid = count_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign count_in = count_ff + 2'(push) - 2'(pop);
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= in_item;
         edge_ff[wr_ptr_ff] <= in_edge;
      end
   end

   assign out_item = item_ff[rd_ptr_ff];
   assign out_edge = edge_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(gtc_pkg::QueueDepth))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(gtc_pkg::QueueDepth)) ||
      (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue push lost");

endmodule

@@ sv/gtc_back.sv @@
module gtc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gtc_pkg::item_type  in_item,
   input  gtc_pkg::edge_type  in_edge [3],
   output logic               out_valid,
   input  logic               out_ready,
   output gtc_pkg::coord_type out_x,
   output gtc_pkg::coord_type out_y,
   output logic               out_inside
);

   localparam int Steps = gtc_pkg::TFrac;
   localparam int NStg  = Steps + 4;

   // Pipelined restoring divider, one quotient bit per stage, then the
   // projection multiply, the distance squares and the nearest pick.
   logic valid_ff [NStg];
   logic adv;
   gtc_pkg::item_type it_ff [NStg];
   gtc_pkg::proj_type pj_ff [Steps+1][3];
   logic [gtc_pkg::LenBits:0] rem_ff [Steps+1][3];
   gtc_pkg::len_type dvs_ff [Steps+1][3];
   gtc_pkg::coord_type qx_ff [3], qy_ff [3];
   logic [gtc_pkg::SumBits-1:0] dd_ff [3];
   gtc_pkg::coord_type res_x_ff, res_y_ff;
   logic res_in_ff;
   gtc_pkg::coord_type qx_pipe_x [3], qx_pipe_y [3];

   assign adv = !valid_ff[NStg-1] || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NStg; s++) valid_ff[s] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < NStg; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff[0] <= in_item;
         for (int s = 1; s < NStg; s++) it_ff[s] <= it_ff[s-1];
         for (int i = 0; i < 3; i++) begin
            pj_ff[0][i].ax <= in_edge[i].ax;
            pj_ff[0][i].ay <= in_edge[i].ay;
            pj_ff[0][i].ex <= in_edge[i].ex;
            pj_ff[0][i].ey <= in_edge[i].ey;
            pj_ff[0][i].degen <= in_edge[i].degen;
            pj_ff[0][i].t <= in_edge[i].t_one ? gtc_pkg::TBits'(1) << gtc_pkg::TFrac
                                                : '0;
            rem_ff[0][i] <= (in_edge[i].t_zero || in_edge[i].t_one) ? '0
                            : {1'b0, in_edge[i].dot};
            dvs_ff[0][i] <= in_edge[i].len2;
            for (int s = 1; s <= Steps; s++) begin
               logic [gtc_pkg::LenBits:0] r2;
               logic ge;
               gtc_pkg::proj_type pn;
               r2 = {rem_ff[s-1][i][gtc_pkg::LenBits-1:0], 1'b0};
               ge = r2 >= {1'b0, dvs_ff[s-1][i]};
               pn = pj_ff[s-1][i];
               pn.t = pn.t | (gtc_pkg::TBits'(ge) << (Steps - s));
               rem_ff[s][i] <= ge ? r2 - {1'b0, dvs_ff[s-1][i]} : r2;
               dvs_ff[s][i] <= dvs_ff[s-1][i];
               pj_ff[s][i] <= pn;
            end
            begin
               logic signed [gtc_pkg::TBits+gtc_pkg::DiffBits:0] mx, my;
               logic signed [gtc_pkg::TBits+gtc_pkg::DiffBits:0] half;
               logic signed [gtc_pkg::TBits+gtc_pkg::DiffBits:0] ax_w, ay_w;
               half = (gtc_pkg::TBits+gtc_pkg::DiffBits+1)'(1) << (gtc_pkg::TFrac-1);
               mx = $signed({1'b0, pj_ff[Steps][i].t}) * pj_ff[Steps][i].ex + half;
               my = $signed({1'b0, pj_ff[Steps][i].t}) * pj_ff[Steps][i].ey + half;
               ax_w = (gtc_pkg::TBits+gtc_pkg::DiffBits+1)'(pj_ff[Steps][i].ax);
               ay_w = (gtc_pkg::TBits+gtc_pkg::DiffBits+1)'(pj_ff[Steps][i].ay);
               qx_ff[i] <= pj_ff[Steps][i].degen ? pj_ff[Steps][i].ax
                           : gtc_pkg::CoordBits'(ax_w + (mx >>> gtc_pkg::TFrac));
               qy_ff[i] <= pj_ff[Steps][i].degen ? pj_ff[Steps][i].ay
                           : gtc_pkg::CoordBits'(ay_w + (my >>> gtc_pkg::TFrac));
            end
            begin
               gtc_pkg::diff_type dx, dy;
               dx = $signed({1'b0, it_ff[Steps+1].px}) - $signed({1'b0, qx_ff[i]});
               dy = $signed({1'b0, it_ff[Steps+1].py}) - $signed({1'b0, qy_ff[i]});
               dd_ff[i] <= gtc_pkg::SumBits'(dx * dx) + gtc_pkg::SumBits'(dy * dy);
            end
         end
         if (it_ff[Steps+2].unchanged) begin
            res_x_ff <= it_ff[Steps+2].px;
            res_y_ff <= it_ff[Steps+2].py;
         end else if (dd_ff[0] <= dd_ff[1] && dd_ff[0] <= dd_ff[2]) begin
            res_x_ff <= qx_pipe_x[0];
            res_y_ff <= qx_pipe_y[0];
         end else if (dd_ff[1] <= dd_ff[2]) begin
            res_x_ff <= qx_pipe_x[1];
            res_y_ff <= qx_pipe_y[1];
         end else begin
            res_x_ff <= qx_pipe_x[2];
            res_y_ff <= qx_pipe_y[2];
         end
         res_in_ff <= it_ff[Steps+2].unchanged;
      end
   end

   // Projections held one more stage to line up with their distances.
   always_ff @(posedge clock) begin
      if (adv) begin
         qx_pipe_x <= qx_ff;
         qx_pipe_y <= qy_ff;
      end
   end

   assign out_valid = valid_ff[NStg-1];
   assign out_x = res_x_ff;
   assign out_y = res_y_ff;
   assign out_inside = res_in_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && adv |=> valid_ff[1])
      else $error("item dropped in back pipeline");
   assert property (@(posedge clock) disable iff (reset)
      out_valid && out_inside |-> out_x == it_ff[NStg-1].px)
      else $error("inside item altered");

endmodule

@@ sv/gamut_triangle_clamp.sv @@
// Gamut triangle clamp.
// A point (req_point_x, req_point_y) enters on the req_ valid/ready channel and
// leaves on the rsp_ channel as (rsp_out_x, rsp_out_y, rsp_was_inside), one
// result per point, in order. Points inside the configured triangle, or all
// points while gamut_valid is clear, pass unchanged; others snap to the nearest
// edge projection.
// Throughput is one point per clock while rsp_ready is held high. A point passes
// two front stages that compute cross products, dot and edge length, then a
// two-entry queue, then sixteen divider stages (one bit of t each), and then
// projection, distance and selection stages.
// When the receiver holds rsp_ready low the back pipeline stops, the queue
// fills and then the front stops, lowering req_ready.
// Reset clears every valid flag and all CSRs to zero (gamut disabled).
// CSRs sit at byte addresses 4*i: red x/y, green x/y, blue x/y, gamut_valid.
// They are to be written only while no point is in flight.
module gamut_triangle_clamp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_point_x,
   input  logic [15:0] req_point_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_out_x,
   output logic [15:0] rsp_out_y,
   output logic        rsp_was_inside,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [gtc_pkg::PaddrBits-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   gtc_pkg::coord_type rx_ff, ry_ff, gx_ff, gy_ff, bx_ff, by_ff;
   logic on_ff;
   logic wr;
   logic [gtc_pkg::PaddrBits-3:0] idx;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign idx = paddr[gtc_pkg::PaddrBits-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= '0; ry_ff <= '0; gx_ff <= '0; gy_ff <= '0;
         bx_ff <= '0; by_ff <= '0; on_ff <= 1'b0;
      end else if (wr) begin
         case (idx)
            gtc_pkg::RegRedX:   rx_ff <= pwdata[15:0];
            gtc_pkg::RegRedY:   ry_ff <= pwdata[15:0];
            gtc_pkg::RegGreenX: gx_ff <= pwdata[15:0];
            gtc_pkg::RegGreenY: gy_ff <= pwdata[15:0];
            gtc_pkg::RegBlueX:  bx_ff <= pwdata[15:0];
            gtc_pkg::RegBlueY:  by_ff <= pwdata[15:0];
            gtc_pkg::RegValid:  on_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         gtc_pkg::RegRedX:   prdata = {16'd0, rx_ff};
         gtc_pkg::RegRedY:   prdata = {16'd0, ry_ff};
         gtc_pkg::RegGreenX: prdata = {16'd0, gx_ff};
         gtc_pkg::RegGreenY: prdata = {16'd0, gy_ff};
         gtc_pkg::RegBlueX:  prdata = {16'd0, bx_ff};
         gtc_pkg::RegBlueY:  prdata = {16'd0, by_ff};
         gtc_pkg::RegValid:  prdata = {31'd0, on_ff};
         default:            prdata = 32'd0;
      endcase
   end

   logic f_valid, f_ready, q_valid, q_ready;
   gtc_pkg::item_type f_item, q_item;
   gtc_pkg::edge_type f_edge [3], q_edge [3];

   gtc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .px(req_point_x), .py(req_point_y),
      .rx(rx_ff), .ry(ry_ff), .gx(gx_ff), .gy(gy_ff), .bx(bx_ff), .by(by_ff),
      .gamut_on(on_ff),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_item(f_item), .out_edge(f_edge)
   );

   gtc_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready),
      .in_item(f_item), .in_edge(f_edge),
      .out_valid(q_valid), .out_ready(q_ready),
      .out_item(q_item), .out_edge(q_edge)
   );

   gtc_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready),
      .in_item(q_item), .in_edge(q_edge),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_x(rsp_out_x), .out_y(rsp_out_y), .out_inside(rsp_was_inside)
   );

endmodule

@@ sim/gamut_triangle_clamp_tb.sv @@
module gamut_triangle_clamp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] qx;
      logic [15:0] qy;
      logic        unchanged;
   } clamp_result_type;

   // Holds the expected clamped points in transfer order and compares them.
   class clamp_scoreboard;
      clamp_result_type pending[$];
      int errors;

      function void note_point(clamp_result_type r);
         pending.push_back(r);
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_result(logic [15:0] ox, logic [15:0] oy, logic ins);
         clamp_result_type e;
         if (pending.size() == 0) begin
            report($sformatf("result (%h,%h,%b) with no point waiting", ox, oy, ins));
            return;
         end
         e = pending.pop_front();
         if (ox !== e.qx || oy !== e.qy || ins !== e.unchanged) begin
            report($sformatf("got (%h,%h,%b) expected (%h,%h,%b)",
                             ox, oy, ins, e.qx, e.qy, e.unchanged));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [15:0] req_point_x = 0;
   logic [15:0] req_point_y = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [15:0] rsp_out_x, rsp_out_y;
   logic rsp_was_inside;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [gtc_pkg::PaddrBits-1:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   gamut_triangle_clamp dut (.*);

   clamp_scoreboard sb = new();
   longint vtx[6];
   bit gamut_on;
   int stall_mode = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint floor_q16(longint v);
      if (v >= 0) return v >>> 16;
      return -((-v + 65535) >>> 16);
   endfunction

   task automatic edge_project(longint ax, ay, bx, by, px, py,
                               output longint qx, output longint qy);
      longint ex, ey, len2, dot, t;
      ex = bx - ax;
      ey = by - ay;
      len2 = ex * ex + ey * ey;
      if (len2 == 0) begin
         qx = ax;
         qy = ay;
         return;
      end
      dot = (px - ax) * ex + (py - ay) * ey;
      if (dot <= 0) t = 0;
      else if (dot >= len2) t = 65536;
      else t = (dot * 65536) / len2;
      qx = ax + floor_q16(t * ex + 32768);
      qy = ay + floor_q16(t * ey + 32768);
   endtask

   task automatic predict_clamp(logic [15:0] x, logic [15:0] y);
      clamp_result_type r;
      longint px, py, s[3], q[3][2], d[3];
      bit neg, pos;
      int k, a, b, best;
      px = x;
      py = y;
      r.qx = x;
      r.qy = y;
      r.unchanged = 1;
      if (gamut_on) begin
         neg = 0;
         pos = 0;
         for (k = 0; k < 3; k++) begin
            a = 2 * k;
            b = 2 * ((k + 1) % 3);
            s[k] = (vtx[b] - vtx[a]) * (py - vtx[a+1])
                   - (vtx[b+1] - vtx[a+1]) * (px - vtx[a]);
            if (s[k] < 0) neg = 1;
            if (s[k] > 0) pos = 1;
         end
         if (neg && pos) begin
            for (k = 0; k < 3; k++) begin
               a = 2 * k;
               b = 2 * ((k + 1) % 3);
               edge_project(vtx[a], vtx[a+1], vtx[b], vtx[b+1], px, py,
                            q[k][0], q[k][1]);
               d[k] = (px - q[k][0]) ** 2 + (py - q[k][1]) ** 2;
            end
            if (d[0] <= d[1] && d[0] <= d[2]) best = 0;
            else if (d[1] <= d[2]) best = 1;
            else best = 2;
            r.qx = q[best][0][15:0];
            r.qy = q[best][1][15:0];
            r.unchanged = 0;
         end
      end
      sb.note_point(r);
   endtask

   // Receiver stall pattern; mode 0 never stalls.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         sb.check_result(rsp_out_x, rsp_out_y, rsp_was_inside);
      case (stall_mode)
         0: rsp_ready <= 1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
   end

   task automatic csr_write(logic [gtc_pkg::PaddrBits-3:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (idx == gtc_pkg::RegValid) gamut_on = value[0];
      else vtx[idx] = value[15:0];
   endtask

   task automatic send_point(logic [15:0] x, logic [15:0] y);
      req_valid <= 1;
      req_point_x <= x;
      req_point_y <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_clamp(x, y);
   endtask

   task automatic idle_sender(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic load_triangle(logic [15:0] v[6], bit en);
      int k;
      for (k = 0; k < 6; k++) csr_write(3'(k), {16'($urandom), v[k]});
      csr_write(gtc_pkg::RegValid, {16'($urandom_range(0, 32767)), 15'd0, en});
   endtask

   function automatic logic [15:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(0, 15));
         3: return 16'(16'hffff - $urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] tri_v[6];
      int k, phase, burst;
      for (k = 0; k < 6; k++) vtx[k] = 0;
      gamut_on = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Gamut disabled: everything passes.
      send_point(16'h0000, 16'h0000);
      send_point(16'hffff, 16'hffff);
      send_point(16'h1234, 16'hedcb);
      drain();

      // A typical triangle, then points inside, on an edge, on a vertex, outside.
      tri_v = '{16'ha3d7, 16'h547a, 16'h4ccc, 16'h999a, 16'h2666, 16'h0f5c};
      load_triangle(tri_v, 1);
      send_point(16'h6000, 16'h5000);
      send_point(16'ha3d7, 16'h547a);
      send_point(16'h7852, 16'h770a);
      send_point(16'h0000, 16'h0000);
      send_point(16'hffff, 16'hffff);
      send_point(16'hffff, 16'h0000);
      send_point(16'h0000, 16'hffff);
      send_point(16'h4ccc, 16'hffff);
      drain();

      // Degenerate edges and a collinear triangle.
      tri_v = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h1000, 16'h2000};
      load_triangle(tri_v, 1);
      send_point(16'h0000, 16'hffff);
      send_point(16'hffff, 16'h0000);
      send_point(16'h4800, 16'h5000);
      drain();
      tri_v = '{16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'hffff, 16'hffff};
      load_triangle(tri_v, 1);
      send_point(16'h4000, 16'h4000);
      send_point(16'h4000, 16'h4001);
      send_point(16'hffff, 16'h0000);
      drain();
      tri_v = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
      load_triangle(tri_v, 1);
      send_point(16'h0000, 16'h0000);
      send_point(16'hffff, 16'hffff);
      drain();

      for (phase = 0; phase < 13; phase++) begin
         for (k = 0; k < 6; k++) tri_v[k] = rnd_coord();
         if (phase == 0) tri_v = '{default: 16'h0000};
         if (phase == 1) tri_v = '{16'hffff, 16'h0000, 16'h0000, 16'hffff,
                                   16'h0000, 16'h0000};
         load_triangle(tri_v, phase % 5 != 4);
         k = 0;
         while (k < 100) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
               if (k < 100) begin
                  send_point(rnd_coord(), rnd_coord());
                  k++;
               end
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
            if (phase == 6 && k > 50 && k < 70) begin
               // Hold off until the pipeline has fully emptied.
               req_valid <= 0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
